>>> hw/rtl/sckt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sckt_pkg - shared types and constants of the pressed key tracker
// Scan code set 1 constants, the queued key event type, the back end
// state type and the code classification functions.
// ----------------------------------------------------------------------------
package sckt_pkg;

   // default number of key slots
   localparam int unsigned MAX_HELD_DEFAULT = 4;

   // number of slots visible on the result ports
   localparam int unsigned REPORT_SLOTS = 4;

   // depth of the queue between the front and back ends
   localparam int unsigned QUEUE_DEPTH = 2;

   // scan code set 1 bytes
   localparam logic [7:0] PREFIX_BYTE  = 8'hE0;
   localparam logic [7:0] RELEASE_BIT  = 8'h80;
   localparam logic [7:0] PLAIN_LAST   = 8'h3A;
   localparam logic [7:0] PLAIN_SKIP_A = 8'h29;
   localparam logic [7:0] PLAIN_SKIP_B = 8'h37;
   localparam logic [7:0] PLAIN_EXTRA  = 8'h56;
   localparam logic [7:0] EXT_ALT      = 8'h38;
   localparam logic [7:0] EXT_UP       = 8'h48;
   localparam logic [7:0] EXT_LEFT     = 8'h4B;
   localparam logic [7:0] EXT_RIGHT    = 8'h4D;
   localparam logic [7:0] EXT_DOWN     = 8'h50;
   localparam logic [7:0] EXT_GUI      = 8'h5B;

   // one classified key event
   typedef struct packed {
      logic       release_key;
      logic [6:0] code;
   } sckt_op_type;

   // front end to queue
   typedef struct packed {
      logic        push;
      sckt_op_type op;
   } sckt_push_type;

   // queue to back end
   typedef struct packed {
      logic        empty;
      sckt_op_type op;
   } sckt_head_type;

   // back end sequencer states
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_APPLY
   } sckt_bk_state_type;

   // plain codes that are tracked
   function automatic logic plain_handled(input logic [7:0] c);
      return ((c >= 8'h01) && (c <= PLAIN_LAST) && (c != PLAIN_SKIP_A) &&
              (c != PLAIN_SKIP_B)) || (c == PLAIN_EXTRA);
   endfunction

   // extended codes that are tracked
   function automatic logic ext_handled(input logic [7:0] c);
      return (c == EXT_ALT) || (c == EXT_UP) || (c == EXT_LEFT) ||
             (c == EXT_RIGHT) || (c == EXT_DOWN) || (c == EXT_GUI);
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/sckt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sckt_front - byte intake and classification
// Tracks the extended prefix, splits press from release and drops codes
// that are not tracked. Tracked events go to the queue.
// ----------------------------------------------------------------------------
module sckt_front
   import sckt_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [7:0]    req_scan_byte,
   input  wire logic          queue_full,
   output logic               busy,
   output sckt_push_type      push_out
);

   logic       prefix_ff;
   logic       prefix_in;
   logic       accept;
   logic       is_release;
   logic [7:0] code8;
   logic       handled;

   assign busy   = queue_full;
   assign accept = start && !queue_full;

   // classify the byte against the current prefix state
   always_comb begin
      is_release = req_scan_byte > RELEASE_BIT;
      code8      = is_release ? (req_scan_byte - RELEASE_BIT) : req_scan_byte;
      handled    = prefix_ff ? ext_handled(code8) : plain_handled(code8);
      prefix_in  = prefix_ff;
      push_out.push            = 1'b0;
      push_out.op.release_key  = is_release;
      push_out.op.code         = code8[6:0];
      if (accept) begin
         if (!prefix_ff && (req_scan_byte == PREFIX_BYTE)) begin
            prefix_in = 1'b1;
         end else begin
            prefix_in     = 1'b0;
            push_out.push = handled;
         end
      end
   end

   // prefix flag
   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= 1'b0;
      end else begin
         prefix_ff <= prefix_in;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/sckt_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sckt_queue - short event queue
// Small first-in first-out store of key events between the front and
// back ends.
// ----------------------------------------------------------------------------
module sckt_queue
   import sckt_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire sckt_push_type push_in,
   input  wire logic          pop,
   output logic               full,
   output sckt_head_type      head
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(QUEUE_DEPTH - 1);

   sckt_op_type      entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (fill_ff == DEPTH_C);
   assign head.empty = (fill_ff == '0);
   assign head.op    = entry_ff[rd_ptr_ff];

   assign do_push = push_in.push && !full;
   assign do_pop  = pop && !head.empty;

   // pointer and fill updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_C) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_C) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_in.op;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/sckt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sckt_back - held key set sequencer
// Pops one event, scans the held slots one per cycle for its code, then
// adds or removes the code, strobing a report after each add and release.
// ----------------------------------------------------------------------------
module sckt_back
   import sckt_pkg::*;
#(
   parameter int unsigned MAX_HELD = MAX_HELD_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire sckt_head_type head,
   output logic               pop,
   output logic               rsp_strobe,
   output logic [2:0]         rsp_held_count,
   output logic [6:0]         rsp_slot_zero,
   output logic [6:0]         rsp_slot_one,
   output logic [6:0]         rsp_slot_two,
   output logic [6:0]         rsp_slot_three
);

   localparam int unsigned IDX_W = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_HELD + 1);
   localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_HELD);

   sckt_bk_state_type state_ff, state_in;
   sckt_op_type       op_ff, op_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              found_ff, found_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [6:0]        slot_ff [MAX_HELD];
   logic [6:0]        slot_in [MAX_HELD];
   logic              strobe_ff, strobe_in;
   logic              in_range;
   logic              hit;
   logic              scan_end;
   logic              load_op;
   logic              scan_step;
   logic              apply_op;
   logic [6:0]        report [REPORT_SLOTS];

   // slot compare at the scan index
   assign in_range = idx_ff < count_ff;
   assign hit      = in_range && (slot_ff[idx_ff[IDX_W-1:0]] == op_ff.code);
   assign scan_end = !in_range || hit;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:  if (!head.empty) state_in = BK_SCAN;
         BK_SCAN:  if (scan_end) state_in = BK_APPLY;
         BK_APPLY: state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      load_op   = 1'b0;
      scan_step = 1'b0;
      apply_op  = 1'b0;
      case (state_ff)
         BK_IDLE:  load_op   = !head.empty;
         BK_SCAN:  scan_step = 1'b1;
         BK_APPLY: apply_op  = 1'b1;
         default:  load_op   = 1'b0;
      endcase
   end

   assign pop = load_op;

   // datapath next values
   always_comb begin
      op_in     = op_ff;
      idx_in    = idx_ff;
      found_in  = found_ff;
      count_in  = count_ff;
      strobe_in = 1'b0;
      for (int j = 0; j < MAX_HELD; j++) begin
         slot_in[j] = slot_ff[j];
      end
      if (load_op) begin
         op_in    = head.op;
         idx_in   = '0;
         found_in = 1'b0;
      end
      if (scan_step) begin
         if (hit) begin
            found_in = 1'b1;
         end else if (in_range) begin
            idx_in = idx_ff + 1'b1;
         end
      end
      if (apply_op) begin
         if (op_ff.release_key) begin
            // remove the code and close the gap, the last slot stays stale
            strobe_in = 1'b1;
            if (found_ff) begin
               for (int j = 0; j < MAX_HELD - 1; j++) begin
                  if ((CNT_W'(j) >= idx_ff) && (CNT_W'(j + 1) < count_ff)) begin
                     slot_in[j] = slot_ff[j + 1];
                  end
               end
               count_in = count_ff - 1'b1;
            end
         end else if (!found_ff && (count_ff < MAX_C)) begin
            // add a new code at the end of the set
            slot_in[count_ff[IDX_W-1:0]] = op_ff.code;
            count_in  = count_ff + 1'b1;
            strobe_in = 1'b1;
         end
      end
   end

   // control and set registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         found_ff  <= 1'b0;
         idx_ff    <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
         for (int j = 0; j < MAX_HELD; j++) begin
            slot_ff[j] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         found_ff  <= found_in;
         idx_ff    <= idx_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
         for (int j = 0; j < MAX_HELD; j++) begin
            slot_ff[j] <= slot_in[j];
         end
      end
   end

   // current event
   always_ff @(posedge clock) begin
      op_ff <= op_in;
   end

   // report view, slots past MAX_HELD read as zero
   for (genvar k = 0; k < REPORT_SLOTS; k++) begin : g_report
      if (k < MAX_HELD) begin : g_slot
         assign report[k] = slot_ff[k];
      end else begin : g_zero
         assign report[k] = '0;
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_held_count = 3'(count_ff);
   assign rsp_slot_zero  = report[0];
   assign rsp_slot_one   = report[1];
   assign rsp_slot_two   = report[2];
   assign rsp_slot_three = report[3];

endmodule
`default_nettype wire

>>> hw/rtl/scan_code_pressed_key_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scan_code_pressed_key_tracker - scan code set 1 pressed key tracker
// Follows keyboard bytes and keeps the set of held keys, reporting the
// set after each added key and each tracked release.
//
//   channel   ports                              handshake
//   request   req_scan_byte                      start high, busy low
//   response  rsp_held_count, rsp_slot_*         rsp_strobe, one cycle
//
// A byte is taken in the cycle it is offered unless the event queue is
// full. The back end takes one queued event at a time: it pops it, scans
// the held slots until it finds the code or passes the last one, then
// updates the set; the report strobes in the cycle after the update.
// Bytes with no tracked event are not queued. The receiver cannot stall.
// Synchronous reset clears the prefix, the queue and the held set to zero.
// ----------------------------------------------------------------------------
module scan_code_pressed_key_tracker
   import sckt_pkg::*;
#(
   parameter int unsigned MAX_HELD = MAX_HELD_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire logic [7:0]    req_scan_byte,
   output logic               rsp_strobe,
   output logic [2:0]         rsp_held_count,
   output logic [6:0]         rsp_slot_zero,
   output logic [6:0]         rsp_slot_one,
   output logic [6:0]         rsp_slot_two,
   output logic [6:0]         rsp_slot_three
);

   sckt_push_type push;
   sckt_head_type head;
   logic          queue_full;
   logic          pop;

   // byte intake
   sckt_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_scan_byte (req_scan_byte),
      .queue_full    (queue_full),
      .busy          (busy),
      .push_out      (push)
   );

   // event queue
   sckt_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .pop     (pop),
      .full    (queue_full),
      .head    (head)
   );

   // held set
   sckt_back #(
      .MAX_HELD (MAX_HELD)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_held_count (rsp_held_count),
      .rsp_slot_zero  (rsp_slot_zero),
      .rsp_slot_one   (rsp_slot_one),
      .rsp_slot_two   (rsp_slot_two),
      .rsp_slot_three (rsp_slot_three)
   );

endmodule
`default_nettype wire
